@@ rtl/core/ybfw_pkg.sv @@
package ybfw_pkg;

	localparam int DIM_W       = 13;
	localparam int COL_W       = 13;
	localparam int ROW_W       = 13;
	localparam int PITCH_W     = 16;
	localparam int SAMPLE_W    = 8;
	localparam int START_W     = 25;
	localparam int DIV_W       = 24;
	localparam int DIV_STEPS   = 24;
	localparam int CNT_W       = 5;
	localparam int ADDR_W      = 32;
	localparam int PIX_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 96;
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = 2;
	localparam int QCNT_W      = 3;

	localparam logic [ROW_W-1:0] ROW_LIMIT = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_WINDOW_X,
		REG_WINDOW_Y,
		REG_PAN_X,
		REG_PAN_Y,
		REG_LINE_PITCH
	} ybfw_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] luma_first;
		logic [SAMPLE_W-1:0] chroma_blue;
		logic [SAMPLE_W-1:0] luma_second;
		logic [SAMPLE_W-1:0] chroma_red;
		logic                chunk;
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
	} ybfw_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ybfw_qstat_t;

	typedef struct packed {
		logic [DIM_W-1:0]   eff_width;
		logic [DIM_W-1:0]   eff_height;
		logic [DIM_W-1:0]   window_x;
		logic [DIM_W-1:0]   window_y;
		logic [DIM_W-1:0]   pan_x;
		logic [DIM_W-1:0]   pan_y;
		logic [PITCH_W-1:0] line_pitch;
	} ybfw_cfg_t;

endpackage

@@ rtl/core/ybfw_front.sv @@
module ybfw_front
	import ybfw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  ybfw_cfg_t             cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [IN_TDATA_W-1:0] in_data,
	input  logic                  in_chunk,
	output logic                  push,
	output ybfw_entry_t           push_entry,
	input  ybfw_qstat_t           qstat
);

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	ybfw_entry_t       item_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [DIV_W-1:0]  quo_q;
	logic [COL_W-1:0]  rem_q;

	logic [COL_W:0]    trial;
	logic [COL_W:0]    diff;
	logic              fits;
	logic [ROW_W-1:0]  div_row;
	ybfw_entry_t       in_entry;

	always_comb begin
		trial   = {rem_q, dvd_q[DIV_W-1]};
		diff    = trial - {1'b0, cfg.eff_width};
		fits    = trial >= {1'b0, cfg.eff_width};
		div_row = (quo_q > DIV_W'(ROW_LIMIT)) ? ROW_LIMIT : quo_q[ROW_W-1:0];

		in_entry.luma_first  = in_data[7:0];
		in_entry.chroma_blue = in_data[15:8];
		in_entry.luma_second = in_data[23:16];
		in_entry.chroma_red  = in_data[31:24];
		in_entry.chunk       = in_chunk;
		in_entry.row         = '0;
		in_entry.col         = '0;

		in_ready = (state_q == F_IDLE) && !qstat.full;
		push     = ((state_q == F_IDLE) && in_valid && !in_chunk && !qstat.full)
			|| ((state_q == F_PUSH) && !qstat.full);

		if (state_q == F_PUSH) begin
			push_entry     = item_q;
			push_entry.row = div_row;
			push_entry.col = rem_q;
		end else begin
			push_entry = in_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					cnt_q <= '0;
					if (in_valid && in_ready && in_chunk) begin
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!qstat.full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid && in_ready && in_chunk) begin
			item_q <= in_entry;
			dvd_q  <= in_data[33 +: DIV_W];
			quo_q  <= '0;
			rem_q  <= '0;
		end else if (state_q == F_DIV) begin
			rem_q <= fits ? diff[COL_W-1:0] : trial[COL_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
		end
	end

`ifndef SYNTHESIS
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIV) |-> (cnt_q < CNT_W'(DIV_STEPS)))
		else $error("Division step count ran past its end.");
`endif

endmodule

@@ rtl/core/ybfw_queue.sv @@
module ybfw_queue
	import ybfw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  ybfw_entry_t push_entry,
	input  logic        pop,
	output ybfw_entry_t pop_entry,
	output ybfw_qstat_t qstat
);

	ybfw_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	always_comb begin
		qstat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
		qstat.empty = count_q == '0;
		do_push     = push && !qstat.full;
		do_pop      = pop && !qstat.empty;
		pop_entry   = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("Queue count exceeds its depth.");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(qstat.empty || qstat.full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("Queue pointers disagree with its count.");
`endif

endmodule

@@ rtl/core/ybfw_back.sv @@
module ybfw_back
	import ybfw_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  ybfw_cfg_t              cfg,
	input  ybfw_qstat_t            qstat,
	input  ybfw_entry_t            q_entry,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data
);

	localparam logic signed [19:0] K_LUMA   = 20'sd298;
	localparam logic signed [19:0] K_RV     = 20'sd409;
	localparam logic signed [19:0] K_GU     = 20'sd100;
	localparam logic signed [19:0] K_GV     = 20'sd208;
	localparam logic signed [19:0] K_BU     = 20'sd516;
	localparam logic signed [19:0] K_ROUND  = 20'sd128;
	localparam logic signed [19:0] K_CHROMA = 20'sd128;
	localparam logic signed [19:0] K_BLACK  = 20'sd16;

	function automatic logic [7:0] clip8(input logic signed [19:0] sum);
		logic [7:0] res;
		if (sum < 0) begin
			res = 8'd0;
		end else if (sum[19:16] != 4'd0) begin
			res = 8'd255;
		end else begin
			res = sum[15:8];
		end
		return res;
	endfunction

	logic             advance;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] pos_col;
	logic [ROW_W-1:0] pos_row;
	logic             in_frame;
	logic [COL_W:0]   col_plus2;
	logic             wrap;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] y0_s1, y1_s1, u_s1, v_s1;
	logic [COL_W-1:0]    col_s1;
	logic [ROW_W-1:0]    row_s1;

	logic               valid_s2;
	logic [COL_W+1:0]   xsum_s2;
	logic [30:0]        yprod_s2;
	logic signed [19:0] l0_s2, l1_s2, rv_s2, gu_s2, gv_s2, bu_s2;

	logic              valid_s3;
	logic [ADDR_W-1:0] addr_s3;
	logic [PIX_W-1:0]  pix0_s3, pix1_s3;

	logic signed [19:0] c0, c1, dd, ee;
	logic [COL_W+1:0]   xsum;
	logic [ROW_W+1:0]   ysum;
	logic signed [19:0] r0, g0, b0, r1, g1, b1;

	always_comb begin
		advance   = !valid_s3 || out_ready;
		pop       = advance && !qstat.empty;
		pos_col   = q_entry.chunk ? q_entry.col : col_q;
		pos_row   = q_entry.chunk ? q_entry.row : row_q;
		in_frame  = pos_row < cfg.eff_height;
		col_plus2 = {1'b0, pos_col} + (COL_W+1)'(2);
		wrap      = col_plus2 >= {1'b0, cfg.eff_width};

		c0   = $signed({12'd0, y0_s1}) - K_BLACK;
		c1   = $signed({12'd0, y1_s1}) - K_BLACK;
		dd   = $signed({12'd0, u_s1}) - K_CHROMA;
		ee   = $signed({12'd0, v_s1}) - K_CHROMA;
		xsum = (COL_W+2)'(col_s1) + (COL_W+2)'(cfg.window_x) + (COL_W+2)'(cfg.pan_x);
		ysum = (ROW_W+2)'(row_s1) + (ROW_W+2)'(cfg.window_y) + (ROW_W+2)'(cfg.pan_y);

		r0 = l0_s2 + rv_s2 + K_ROUND;
		g0 = l0_s2 - gu_s2 - gv_s2 + K_ROUND;
		b0 = l0_s2 + bu_s2 + K_ROUND;
		r1 = l1_s2 + rv_s2 + K_ROUND;
		g1 = l1_s2 - gu_s2 - gv_s2 + K_ROUND;
		b1 = l1_s2 + bu_s2 + K_ROUND;

		out_valid = valid_s3;
		out_data  = {pix1_s3, pix0_s3, addr_s3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (pop) begin
				if (in_frame && wrap) begin
					col_q <= '0;
					row_q <= (pos_row == ROW_LIMIT) ? pos_row : pos_row + ROW_W'(1);
				end else if (in_frame) begin
					col_q <= col_plus2[COL_W-1:0];
					row_q <= pos_row;
				end else begin
					col_q <= pos_col;
					row_q <= pos_row;
				end
			end
			if (advance) begin
				valid_s1 <= pop && in_frame;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			y0_s1  <= q_entry.luma_first;
			y1_s1  <= q_entry.luma_second;
			u_s1   <= q_entry.chroma_blue;
			v_s1   <= q_entry.chroma_red;
			col_s1 <= pos_col;
			row_s1 <= pos_row;

			xsum_s2  <= xsum;
			yprod_s2 <= 31'(ysum) * 31'(cfg.line_pitch);
			l0_s2    <= c0 * K_LUMA;
			l1_s2    <= c1 * K_LUMA;
			rv_s2    <= ee * K_RV;
			gu_s2    <= dd * K_GU;
			gv_s2    <= ee * K_GV;
			bu_s2    <= dd * K_BU;

			addr_s3 <= ADDR_W'({xsum_s2, 2'b00}) + ADDR_W'(yprod_s2);
			pix0_s3 <= {8'hFF, clip8(r0), clip8(g0), clip8(b0)};
			pix1_s3 <= {8'hFF, clip8(r1), clip8(g1), clip8(b1)};
		end
	end

`ifndef SYNTHESIS
	a_bubble_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !valid_s1) |=> !valid_s2)
		else $error("A pipeline bubble turned into a valid stage.");
`endif

endmodule

@@ rtl/core/yuyv_to_bgra_framebuffer_writer.sv @@
// Converts a stream of YUYV macropixels into pairs of BGRA framebuffer pixels.
// Each request on the s_axis channel carries one macropixel; s_axis_tuser marks
// the first macropixel of a chunk, whose start byte sets the row and column.
// Each request on the m_axis channel carries the byte address of the first
// pixel and both 32-bit pixel words. A macropixel that falls below the last
// row of the frame gives no request on m_axis.
// Ordinary macropixels are taken at one per cycle while the queue has room and
// pass through the queue and the pipeline registers s1, s2 and s3 to m_axis.
// A chunk start runs a one-bit-per-cycle divider in the front end; the next
// request is accepted only once the chunk start has been pushed into the queue.
// A four-entry queue separates the front end from the conversion pipeline.
// When m_axis_tready is low the pipeline holds and the queue fills, after
// which s_axis_tready drops. Reset clears the position to row 0, column 0,
// empties the queue and loads the registers with their defaults. The user
// must see that registers are written through cfg_we, cfg_index and cfg_wdata
// only while no request is in flight; nothing in the block enforces this.
module yuyv_to_bgra_framebuffer_writer
	import ybfw_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// luma_first, chroma_blue, luma_second, chroma_red, chunk_start_byte, zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// chunk_first
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// pixel_address, first_pixel, second_pixel
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	logic [DIM_W-1:0]   frame_width_q;
	logic [DIM_W-1:0]   frame_height_q;
	logic [DIM_W-1:0]   window_x_q;
	logic [DIM_W-1:0]   window_y_q;
	logic [DIM_W-1:0]   pan_x_q;
	logic [DIM_W-1:0]   pan_y_q;
	logic [PITCH_W-1:0] line_pitch_q;

	logic [DIM_W-1:0] width_even;
	ybfw_cfg_t        cfg;
	logic             push;
	logic             pop;
	ybfw_entry_t      push_entry;
	ybfw_entry_t      pop_entry;
	ybfw_qstat_t      qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_W'(640);
			frame_height_q <= DIM_W'(480);
			window_x_q     <= '0;
			window_y_q     <= '0;
			pan_x_q        <= '0;
			pan_y_q        <= '0;
			line_pitch_q   <= PITCH_W'(2560);
		end else if (cfg_we) begin
			unique case (ybfw_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[DIM_W-1:0];
				REG_WINDOW_X:     window_x_q     <= cfg_wdata[DIM_W-1:0];
				REG_WINDOW_Y:     window_y_q     <= cfg_wdata[DIM_W-1:0];
				REG_PAN_X:        pan_x_q        <= cfg_wdata[DIM_W-1:0];
				REG_PAN_Y:        pan_y_q        <= cfg_wdata[DIM_W-1:0];
				REG_LINE_PITCH:   line_pitch_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		width_even = {frame_width_q[DIM_W-1:1], 1'b0};
		if (width_even < DIM_W'(2)) begin
			cfg.eff_width = DIM_W'(2);
		end else if ({1'b0, width_even} > (DIM_W+1)'(MAX_WIDTH)) begin
			cfg.eff_width = DIM_W'(MAX_WIDTH & ~1);
		end else begin
			cfg.eff_width = width_even;
		end
		if ({1'b0, frame_height_q} > (DIM_W+1)'(MAX_HEIGHT)) begin
			cfg.eff_height = DIM_W'(MAX_HEIGHT);
		end else begin
			cfg.eff_height = frame_height_q;
		end
		cfg.window_x   = window_x_q;
		cfg.window_y   = window_y_q;
		cfg.pan_x      = pan_x_q;
		cfg.pan_y      = pan_y_q;
		cfg.line_pitch = line_pitch_q;
	end

	ybfw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.in_chunk   (s_axis_tuser),
		.push       (push),
		.push_entry (push_entry),
		.qstat      (qstat)
	);

	ybfw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.qstat      (qstat)
	);

	ybfw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.qstat     (qstat),
		.q_entry   (pop_entry),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

@@ bench/tb_yuyv_to_bgra_framebuffer_writer.sv @@
module tb_yuyv_to_bgra_framebuffer_writer;
	import ybfw_pkg::*;

	localparam int MAX_W        = 4096;
	localparam int MAX_H        = 4096;
	localparam int NUM_REGS     = 7;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 600000;
	localparam logic [START_W-1:0] START_MAX = '1;

	typedef struct {
		logic [ADDR_W-1:0] address;
		logic [PIX_W-1:0]  first_pixel;
		logic [PIX_W-1:0]  second_pixel;
	} pixel_pair_t;

	class pixel_pair_scoreboard;
		int unsigned regs [NUM_REGS];
		int unsigned column;
		int unsigned row;
		pixel_pair_t pending_pairs [$];
		int errors;

		function new();
			regs[REG_FRAME_WIDTH]  = 640;
			regs[REG_FRAME_HEIGHT] = 480;
			regs[REG_WINDOW_X]     = 0;
			regs[REG_WINDOW_Y]     = 0;
			regs[REG_PAN_X]        = 0;
			regs[REG_PAN_Y]        = 0;
			regs[REG_LINE_PITCH]   = 2560;
			column = 0;
			row = 0;
			errors = 0;
		endfunction

		function void write_reg(ybfw_reg_t idx, int unsigned value);
			regs[idx] = value;
		endfunction

		function int pending();
			return pending_pairs.size();
		endfunction

		function int unsigned width_used();
			int unsigned w;
			w = regs[REG_FRAME_WIDTH] & ~32'd1;
			if (w < 2) w = 2;
			if (w > MAX_W) w = MAX_W & ~1;
			return w;
		endfunction

		function int unsigned height_used();
			return (regs[REG_FRAME_HEIGHT] > MAX_H) ? MAX_H : regs[REG_FRAME_HEIGHT];
		endfunction

		function logic [7:0] clip(int sum);
			if (sum < 0) return 8'd0;
			if ((sum >>> 8) > 255) return 8'hFF;
			return 8'(sum >>> 8);
		endfunction

		function logic [PIX_W-1:0] to_bgra(int y, int u, int v);
			int c, d, e;
			c = y - 16;
			d = u - 128;
			e = v - 128;
			return {8'hFF, clip(298 * c + 409 * e + 128),
				clip(298 * c - 100 * d - 208 * e + 128), clip(298 * c + 516 * d + 128)};
		endfunction

		function void note_macropixel(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
				logic [7:0] v, logic chunk, logic [START_W-1:0] start);
			int unsigned w, h, r;
			pixel_pair_t p;
			w = width_used();
			h = height_used();
			if (chunk) begin
				r = start / (2 * w);
				row = (r > ROW_LIMIT) ? ROW_LIMIT : r;
				column = (start / 2) % w;
			end
			if (row >= h) return;
			p.address = (column + regs[REG_WINDOW_X] + regs[REG_PAN_X]) * 4 +
				(row + regs[REG_WINDOW_Y] + regs[REG_PAN_Y]) * regs[REG_LINE_PITCH];
			p.first_pixel = to_bgra(y0, u, v);
			p.second_pixel = to_bgra(y1, u, v);
			pending_pairs.push_back(p);
			column += 2;
			if (column >= w) begin
				column = 0;
				if (row < ROW_LIMIT) row++;
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= 10) $display("%s: expected %h, got %h", name, want, got);
			end
		endfunction

		function void check_pair(logic [OUT_TDATA_W-1:0] data);
			pixel_pair_t want;
			if (pending_pairs.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected pixel pair %h", data);
				return;
			end
			want = pending_pairs.pop_front();
			compare_field("pixel_address", want.address, data[31:0]);
			compare_field("first_pixel", want.first_pixel, data[63:32]);
			compare_field("second_pixel", want.second_pixel, data[95:64]);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	pixel_pair_scoreboard sb = new();
	int accepted_inputs = 0;
	bit dense_burst = 0;

	yuyv_to_bgra_framebuffer_writer #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 0;
		#10;
		clk = 1;
		#10;
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function int send_gap();
		if (dense_burst || $urandom_range(0, 99) < 60) return 0;
		return pick_gap();
	endfunction

	function logic [7:0] sample();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd16;
			3: return 8'd235;
			4: return 8'd128;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function int unsigned pick_offset();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 8191;
			default: return $urandom_range(0, 8191);
		endcase
	endfunction

	task automatic send_item(logic [7:0] y0, logic [7:0] u, logic [7:0] y1, logic [7:0] v,
			logic chunk, logic [START_W-1:0] start);
		int gap;
		gap = send_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, start, v, y1, u, y0};
		s_axis_tuser <= chunk;
		do @(negedge clk); while (!s_axis_tready);
		sb.note_macropixel(y0, u, y1, v, chunk, start);
		accepted_inputs++;
		@(posedge clk);
	endtask

	task automatic send_random(logic chunk, logic [START_W-1:0] start);
		send_item(sample(), sample(), sample(), sample(), chunk, start);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(int unsigned w, int unsigned h, int unsigned wx, int unsigned wy,
			int unsigned px, int unsigned py, int unsigned pitch);
		int unsigned vals [NUM_REGS];
		ybfw_reg_t idx;
		vals[REG_FRAME_WIDTH]  = w;
		vals[REG_FRAME_HEIGHT] = h;
		vals[REG_WINDOW_X]     = wx;
		vals[REG_WINDOW_Y]     = wy;
		vals[REG_PAN_X]        = px;
		vals[REG_PAN_Y]        = py;
		vals[REG_LINE_PITCH]   = pitch;
		idx = idx.first();
		forever begin
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_wdata <= CFG_DATA_W'(vals[idx]);
			sb.write_reg(idx, vals[idx]);
			@(posedge clk);
			if (idx == idx.last()) break;
			idx = idx.next();
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_config();
		int unsigned w, h;
		case ($urandom_range(0, 7))
			0: w = 2;
			1: w = 4096;
			2: w = 8191;
			3: w = $urandom_range(0, 31) * 2 + 1;
			default: w = $urandom_range(1, 32) * 2;
		endcase
		case ($urandom_range(0, 7))
			0, 1: h = 1;
			2: h = 8191;
			3: h = 4096;
			default: h = $urandom_range(2, 12);
		endcase
		configure(w, h, pick_offset(), pick_offset(), pick_offset(), pick_offset(),
			($urandom_range(0, 4) == 0) ? 0 :
			($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535));
	endtask

	task automatic random_phase(int n_items);
		int sent, run;
		longint unsigned upper;
		logic [START_W-1:0] start;
		sent = 0;
		while (sent < n_items) begin
			dense_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 85) begin
				upper = 2 * sb.width_used() * sb.height_used() + 4 * sb.width_used();
				if (upper > START_MAX) upper = START_MAX;
				start = START_W'($urandom_range(0, int'(upper)));
				if ($urandom_range(0, 9) != 0) start[0] = 1'b0;
				send_random(1'b1, start);
				sent++;
				run = $urandom_range(1, 30);
				if (run > n_items - sent) run = n_items - sent;
				repeat (run) begin
					send_random(1'b0, START_W'($urandom));
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 3)) begin
					send_random(1'($urandom), START_W'($urandom));
					sent++;
				end
			end
		end
		dense_burst = 0;
	endtask

	initial begin
		m_axis_tready = 1'b0;
		fork
			begin : receiver
				int stall_left, calm_left, r;
				bit held_first, held_second;
				stall_left = 0;
				calm_left = 0;
				held_first = 0;
				held_second = 0;
				forever begin
					@(posedge clk);
					if (!held_first && accepted_inputs >= 200) begin
						held_first = 1;
						stall_left = 120;
					end
					if (!held_second && accepted_inputs >= 450) begin
						held_second = 1;
						stall_left = 120;
					end
					if (stall_left > 0) begin
						m_axis_tready <= 1'b0;
						stall_left--;
					end else begin
						m_axis_tready <= 1'b1;
						if (calm_left > 0) begin
							calm_left--;
						end else begin
							r = $urandom_range(0, 99);
							if (r < 4) calm_left = 60;
							else if (r < 24) stall_left = pick_gap();
						end
					end
					@(negedge clk);
					if (m_axis_tvalid && m_axis_tready) sb.check_pair(m_axis_tdata);
				end
			end
		join_none
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("yuyv_to_bgra_framebuffer_writer: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Small frame: sample extremes, odd column start, last row and past the frame.
		configure(8, 4, 3, 2, 1, 5, 100);
		send_item(8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 0);
		send_item(8'd255, 8'd255, 8'd0, 8'd0, 1'b0, 0);
		send_item(8'd16, 8'd128, 8'd235, 8'd128, 1'b0, 0);
		send_item(8'd16, 8'd240, 8'd16, 8'd16, 1'b0, 0);
		send_random(1'b1, 3);
		send_random(1'b0, 0);
		send_random(1'b0, 0);
		send_random(1'b0, 0);
		send_random(1'b1, 62);
		send_random(1'b0, 0);
		send_random(1'b1, START_MAX);
		send_random(1'b1, 16);
		settle();

		// Zero width and zero height: nothing comes out.
		configure(0, 0, 0, 0, 0, 0, 1);
		send_random(1'b1, 5);
		send_random(1'b0, 0);
		settle();

		// Every register at its maximum.
		configure(8191, 8191, 8191, 8191, 8191, 8191, 65535);
		send_random(1'b1, 0);
		send_random(1'b0, 0);
		send_random(1'b1, START_MAX);
		send_random(1'b0, 0);
		settle();

		// Odd width, single row, zero pitch.
		configure(7, 1, 0, 0, 0, 0, 0);
		send_random(1'b1, 4);
		send_random(1'b0, 0);
		send_random(1'b0, 0);
		settle();

		configure(4, 3, 0, 8191, 8191, 0, 65535);
		random_phase(65);
		settle();
		configure(8191, 8191, 8191, 8191, 8191, 8191, 65535);
		random_phase(65);
		settle();
		configure(2, 1, 0, 0, 0, 0, 0);
		random_phase(65);
		settle();
		repeat (7) begin
			random_config();
			random_phase(65);
			settle();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("yuyv_to_bgra_framebuffer_writer: match");
		end else begin
			$display("yuyv_to_bgra_framebuffer_writer: mismatch");
		end
		$finish;
	end

endmodule
